FILE: rtl/core/adsp_pkg.sv
// ----------------------------------------------------------------------------
// adsp_pkg
// Shared widths, register indexes and control types for the
// advection-diffusion stencil point core.
// ----------------------------------------------------------------------------
package adsp_pkg;

  // Fixed-point format of values and coefficients.
  localparam int VALUE_BITS = 24;
  localparam int FRAC_BITS  = 16;

  // Derived widths.
  localparam int VAL_W   = VALUE_BITS - 1;
  localparam int COEF_W  = VALUE_BITS;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int LAP_W   = VAL_W + 3;
  localparam int VPROD_W = 2 * VALUE_BITS;
  localparam int RATE_W  = VPROD_W - FRAC_BITS + 1;
  localparam int APROD_W = RATE_W + COEF_W + 1;
  localparam int DPROD_W = LAP_W + COEF_W + 1;
  localparam int ACC_W   = APROD_W + 2;
  localparam int RES_W   = ACC_W - FRAC_BITS;

  // Pipeline depth.
  localparam int NSTAGE = 6;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_ADV_X  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ADV_Y  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DIFF_X = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DIFF_Y = 2'd3;

  // Coefficient set held by the configuration registers.
  typedef struct packed {
    logic [COEF_W-1:0] adv_x;
    logic [COEF_W-1:0] adv_y;
    logic [COEF_W-1:0] diff_x;
    logic [COEF_W-1:0] diff_y;
  } adsp_coef_t;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } adsp_ctl_t;

endpackage

FILE: rtl/core/advection_diffusion_stencil_point_core.sv
// ----------------------------------------------------------------------------
// advection_diffusion_stencil_point_core
// One explicit advection-diffusion time step at a single grid point.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one grid point per transfer: the centre value,
//   its four neighbours, both velocity components and the boundary flag.
//   The output channel returns one transfer per point with the new value
//   and a flag set when it was clipped at the top of its range.
//   Both channels use valid and stall; a transfer happens when valid is
//   high and stall is low.
//   The four coefficients are written through the cfg_ port while no point
//   is in flight; they are zero after reset.
//   Throughput is one point per cycle while the receiver does not stall,
//   set by the six-stage multiplier pipeline.
//   Reset empties the pipeline and clears the coefficients.
//   When the receiver stalls, results hold in place and empty stages
//   still fill; the input stalls only once every stage is occupied.
// ----------------------------------------------------------------------------
module advection_diffusion_stencil_point_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [adsp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [adsp_pkg::COEF_W-1:0]            cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [adsp_pkg::VAL_W-1:0]             in_center,
  input  logic [adsp_pkg::VAL_W-1:0]             in_west,
  input  logic [adsp_pkg::VAL_W-1:0]             in_east,
  input  logic [adsp_pkg::VAL_W-1:0]             in_north,
  input  logic [adsp_pkg::VAL_W-1:0]             in_south,
  input  logic signed [adsp_pkg::VALUE_BITS-1:0] in_vel_x,
  input  logic signed [adsp_pkg::VALUE_BITS-1:0] in_vel_y,
  input  logic                                   in_on_edge,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [adsp_pkg::VAL_W-1:0]             out_updated,
  output logic                                   out_saturated
);
  import adsp_pkg::*;

  adsp_coef_t coef;
  adsp_ctl_t  ctl;

  // Coefficient registers.
  adsp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  // Valid bits and back-pressure.
  adsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Arithmetic pipeline.
  adsp_datapath u_dp (
    .clk           (clk),
    .ctl           (ctl),
    .coef          (coef),
    .in_center     (in_center),
    .in_west       (in_west),
    .in_east       (in_east),
    .in_north      (in_north),
    .in_south      (in_south),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_on_edge    (in_on_edge),
    .out_updated   (out_updated),
    .out_saturated (out_saturated)
  );

endmodule

FILE: rtl/core/adsp_cfg.sv
// ----------------------------------------------------------------------------
// adsp_cfg
// Configuration register file holding the four precomputed coefficients.
// ----------------------------------------------------------------------------
module adsp_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [adsp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [adsp_pkg::COEF_W-1:0]       cfg_wdata,
  output adsp_pkg::adsp_coef_t              coef
);
  import adsp_pkg::*;

  adsp_coef_t coef_r;
  adsp_coef_t coef_nxt;

  // Decode the register index of a write.
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_ADV_X:  coef_nxt.adv_x  = cfg_wdata;
        REG_ADV_Y:  coef_nxt.adv_y  = cfg_wdata;
        REG_DIFF_X: coef_nxt.diff_x = cfg_wdata;
        REG_DIFF_Y: coef_nxt.diff_y = cfg_wdata;
        default:    coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

FILE: rtl/core/adsp_ctrl.sv
// ----------------------------------------------------------------------------
// adsp_ctrl
// Valid bits and back-pressure chain of the six-stage pipeline.
// ----------------------------------------------------------------------------
module adsp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output adsp_pkg::adsp_ctl_t  ctl
);
  import adsp_pkg::*;

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE:0]   ready;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    ready[NSTAGE] = !out_stall;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      ready[k] = !vld_r[k] || ready[k+1];
    end
  end

  // Valid bits follow their data forward.
  always_comb begin
    for (int k = 0; k < NSTAGE; k++) begin
      if (ready[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en    = ready[NSTAGE-1:0];
  assign in_stall  = !ready[0];
  assign out_valid = vld_r[NSTAGE-1];

endmodule

FILE: rtl/core/adsp_datapath.sv
// ----------------------------------------------------------------------------
// adsp_datapath
// Six register stages: differences, products, rounding, advection products,
// accumulation and final rounding with clamp.
// ----------------------------------------------------------------------------
module adsp_datapath (
  input  logic                           clk,
  input  adsp_pkg::adsp_ctl_t            ctl,
  input  adsp_pkg::adsp_coef_t           coef,
  input  logic [adsp_pkg::VAL_W-1:0]     in_center,
  input  logic [adsp_pkg::VAL_W-1:0]     in_west,
  input  logic [adsp_pkg::VAL_W-1:0]     in_east,
  input  logic [adsp_pkg::VAL_W-1:0]     in_north,
  input  logic [adsp_pkg::VAL_W-1:0]     in_south,
  input  logic signed [adsp_pkg::VALUE_BITS-1:0] in_vel_x,
  input  logic signed [adsp_pkg::VALUE_BITS-1:0] in_vel_y,
  input  logic                           in_on_edge,
  output logic [adsp_pkg::VAL_W-1:0]     out_updated,
  output logic                           out_saturated
);
  import adsp_pkg::*;

  localparam logic signed [VPROD_W:0] VHALF = (VPROD_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] AHALF = ACC_W'(1) << (FRAC_BITS - 1);

  // Centre value and boundary flag travel alongside every stage.
  logic [VAL_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r;
  logic             e1_r, e2_r, e3_r, e4_r, e5_r;

  // Stage 1: upwind differences and Laplacian sums.
  logic signed [DIFF_W-1:0]     dx_nxt, dy_nxt, dx_r, dy_r;
  logic signed [LAP_W-1:0]      lx_nxt, ly_nxt, lx_r, ly_r;
  logic signed [VALUE_BITS-1:0] vx1_r, vy1_r;
  logic signed [DIFF_W-1:0]     cw, ec, cn, sc;
  logic                         vx_pos, vy_pos;

  always_comb begin
    cw = $signed({1'b0, in_center}) - $signed({1'b0, in_west});
    ec = $signed({1'b0, in_east})   - $signed({1'b0, in_center});
    cn = $signed({1'b0, in_center}) - $signed({1'b0, in_north});
    sc = $signed({1'b0, in_south})  - $signed({1'b0, in_center});
    vx_pos = !in_vel_x[VALUE_BITS-1] && (in_vel_x != '0);
    vy_pos = !in_vel_y[VALUE_BITS-1] && (in_vel_y != '0);
    dx_nxt = vx_pos ? cw : ec;
    dy_nxt = vy_pos ? cn : sc;
    lx_nxt = $signed(LAP_W'(in_west) + LAP_W'(in_east) - (LAP_W'(in_center) << 1));
    ly_nxt = $signed(LAP_W'(in_north) + LAP_W'(in_south) - (LAP_W'(in_center) << 1));
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      lx_r  <= lx_nxt;
      ly_r  <= ly_nxt;
      vx1_r <= in_vel_x;
      vy1_r <= in_vel_y;
      c1_r  <= in_center;
      e1_r  <= in_on_edge;
    end
  end

  // Stage 2: velocity times difference, diffusion products.
  logic signed [VPROD_W-1:0] pvx_nxt, pvy_nxt, pvx_r, pvy_r;
  logic signed [DPROD_W-1:0] pdx_nxt, pdy_nxt, pdx_r, pdy_r;

  always_comb begin
    pvx_nxt = vx1_r * dx_r;
    pvy_nxt = vy1_r * dy_r;
    pdx_nxt = lx_r * $signed({1'b0, coef.diff_x});
    pdy_nxt = ly_r * $signed({1'b0, coef.diff_y});
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      pvx_r <= pvx_nxt;
      pvy_r <= pvy_nxt;
      pdx_r <= pdx_nxt;
      pdy_r <= pdy_nxt;
      c2_r  <= c1_r;
      e2_r  <= e1_r;
    end
  end

  // Stage 3: round the rates to the value grid, sum the diffusion side.
  logic signed [VPROD_W:0]   rvx, rvy, pvx_ext, pvy_ext;
  logic signed [RATE_W-1:0]  rx_r, ry_r;
  logic signed [ACC_W-1:0]   cacc, pdx_ext, pdy_ext, ds_nxt, ds3_r;

  always_comb begin
    pvx_ext = (VPROD_W + 1)'(pvx_r);
    pvy_ext = (VPROD_W + 1)'(pvy_r);
    rvx     = pvx_ext + VHALF;
    rvy     = pvy_ext + VHALF;
    cacc    = $signed(ACC_W'({c2_r, {(2 * FRAC_BITS){1'b0}}}));
    pdx_ext = ACC_W'(pdx_r);
    pdy_ext = ACC_W'(pdy_r);
    ds_nxt  = cacc + pdx_ext + pdy_ext;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      rx_r  <= rvx[VPROD_W:FRAC_BITS];
      ry_r  <= rvy[VPROD_W:FRAC_BITS];
      ds3_r <= ds_nxt;
      c3_r  <= c2_r;
      e3_r  <= e2_r;
    end
  end

  // Stage 4: advection products.
  logic signed [APROD_W-1:0] ax_nxt, ay_nxt, ax_r, ay_r;
  logic signed [ACC_W-1:0]   ds4_r;

  always_comb begin
    ax_nxt = rx_r * $signed({1'b0, coef.adv_x});
    ay_nxt = ry_r * $signed({1'b0, coef.adv_y});
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
      ds4_r <= ds3_r;
      c4_r  <= c3_r;
      e4_r  <= e3_r;
    end
  end

  // Stage 5: full sum with the rounding half added.
  logic signed [ACC_W-1:0] ax_ext, ay_ext, acc_nxt, acc_r;

  always_comb begin
    ax_ext  = ACC_W'(ax_r);
    ay_ext  = ACC_W'(ay_r);
    acc_nxt = ds4_r - ax_ext - ay_ext + AHALF;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      acc_r <= acc_nxt;
      c5_r  <= c4_r;
      e5_r  <= e4_r;
    end
  end

  // Stage 6: drop the fraction, clamp at zero, saturate at the top.
  logic signed [RES_W-1:0] res;
  logic                    res_neg, res_over;
  logic [VAL_W-1:0]        upd_nxt, upd_r;
  logic                    sat_nxt, sat_r;

  always_comb begin
    res      = acc_r[ACC_W-1:FRAC_BITS];
    res_neg  = res[RES_W-1];
    res_over = !res_neg && (res[RES_W-2:VAL_W] != '0);
    if (e5_r) begin
      upd_nxt = c5_r;
      sat_nxt = 1'b0;
    end else if (res_neg) begin
      upd_nxt = '0;
      sat_nxt = 1'b0;
    end else if (res_over) begin
      upd_nxt = '1;
      sat_nxt = 1'b1;
    end else begin
      upd_nxt = res[VAL_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      upd_r <= upd_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_updated   = upd_r;
  assign out_saturated = sat_r;

endmodule

FILE: rtl/core/adsp_checker.sv
// ----------------------------------------------------------------------------
// adsp_checker
// Port-level checks of the stencil point core, bound to the top level.
// ----------------------------------------------------------------------------
module adsp_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_stall,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic [adsp_pkg::VAL_W-1:0]             out_updated,
  input  logic                                   out_saturated
);
  import adsp_pkg::*;

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The input is held back only when the whole pipeline is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline had room");

  // A saturated result carries the top value.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_updated == '1))
    else $error("saturation flag without the top value");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_updated)
                                  && $stable(out_saturated)))
    else $error("stalled result changed");

endmodule

bind advection_diffusion_stencil_point_core adsp_checker u_adsp_checker (.*);

FILE: tb/sv/advection_diffusion_stencil_point_core_test.sv
// ----------------------------------------------------------------------------
// advection_diffusion_stencil_point_core_test
// Self-checking testbench for the advection-diffusion stencil point core.
// Grid points are streamed in bursts while the result side stalls on its own
// pattern. Every point is run through an in-bench fixed-point predictor when
// its transfer is accepted, and each returned transfer is compared field by
// field with the oldest prediction. Coefficients change between phases, once
// the pipeline has drained.
// ----------------------------------------------------------------------------
module advection_diffusion_stencil_point_core_test;
  import adsp_pkg::*;

  localparam int     LIMIT     = 400000;
  localparam longint CONC_MAX  = (longint'(1) <<< VAL_W) - 1;
  localparam int     PHASES    = 8;
  localparam int     PHASE_LEN = 116;

  typedef struct packed {
    logic [VAL_W-1:0]             center;
    logic [VAL_W-1:0]             west;
    logic [VAL_W-1:0]             east;
    logic [VAL_W-1:0]             north;
    logic [VAL_W-1:0]             south;
    logic signed [VALUE_BITS-1:0] vel_x;
    logic signed [VALUE_BITS-1:0] vel_y;
    logic                         on_edge;
  } grid_point_t;

  typedef struct packed {
    logic [VAL_W-1:0] updated;
    logic             saturated;
  } point_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [CFG_ADDR_W-1:0]        cfg_addr;
  logic [COEF_W-1:0]            cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic [VAL_W-1:0]             in_center;
  logic [VAL_W-1:0]             in_west;
  logic [VAL_W-1:0]             in_east;
  logic [VAL_W-1:0]             in_north;
  logic [VAL_W-1:0]             in_south;
  logic signed [VALUE_BITS-1:0] in_vel_x;
  logic signed [VALUE_BITS-1:0] in_vel_y;
  logic                         in_on_edge;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [VAL_W-1:0]             out_updated;
  logic                         out_saturated;

  // Predictor copy of the coefficient registers and the expected results.
  adsp_coef_t    coef_set;
  point_result_t pending_results[$];
  int            fail_count  = 0;
  int            cycle_count = 0;

  // Sender burst control.
  bit gaps_on    = 1'b1;
  int burst_left = 0;

  // Receiver stall pattern.
  int stall_mode = 0;
  int stall_hold = 0;

  advection_diffusion_stencil_point_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_center     (in_center),
    .in_west       (in_west),
    .in_east       (in_east),
    .in_north      (in_north),
    .in_south      (in_south),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_on_edge    (in_on_edge),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_updated   (out_updated),
    .out_saturated (out_saturated)
  );

  always #2 clk = ~clk;

  // One upwind advection term in Q.2F: the velocity-difference product is
  // rounded to Q.F (halves upwards) before scaling by the coefficient.
  function automatic longint upwind_term(longint vel, longint behind, longint c,
                                         longint ahead, longint coef);
    longint slope;
    longint rate;
    slope = (vel > 0) ? (c - behind) : (ahead - c);
    rate  = (vel * slope + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return rate * coef;
  endfunction

  // New concentration at one grid point after a single explicit time step.
  function automatic point_result_t advance_point(grid_point_t p);
    longint c, w, e, n, s, vx, vy, acc, res;
    point_result_t r;
    c  = longint'(p.center);
    w  = longint'(p.west);
    e  = longint'(p.east);
    n  = longint'(p.north);
    s  = longint'(p.south);
    vx = longint'($signed(p.vel_x));
    vy = longint'($signed(p.vel_y));
    r.saturated = 1'b0;
    r.updated   = p.center;
    if (!p.on_edge) begin
      acc = c <<< (2 * FRAC_BITS);
      acc -= upwind_term(vx, w, c, e, longint'(coef_set.adv_x));
      acc -= upwind_term(vy, n, c, s, longint'(coef_set.adv_y));
      acc += (w - 2 * c + e) * longint'(coef_set.diff_x);
      acc += (n - 2 * c + s) * longint'(coef_set.diff_y);
      res = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (res < 0) begin
        r.updated = '0;
      end else if (res > CONC_MAX) begin
        r.updated   = '1;
        r.saturated = 1'b1;
      end else begin
        r.updated = res[VAL_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic grid_point_t make_point(int c, int w, int e, int n, int s,
                                             int vx, int vy, bit on_edge);
    grid_point_t p;
    p.center  = c[VAL_W-1:0];
    p.west    = w[VAL_W-1:0];
    p.east    = e[VAL_W-1:0];
    p.north   = n[VAL_W-1:0];
    p.south   = s[VAL_W-1:0];
    p.vel_x   = vx[VALUE_BITS-1:0];
    p.vel_y   = vy[VALUE_BITS-1:0];
    p.on_edge = on_edge;
    return p;
  endfunction

  // Concentration drawn from extremes, small values or the full range.
  function automatic int rand_conc();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return int'(CONC_MAX);
      2, 3:    return $urandom_range(0, 1 << 17);
      default: return $urandom_range(0, int'(CONC_MAX));
    endcase
  endfunction

  // Neighbour value, often close to the centre as on a smooth field.
  function automatic int rand_neighbour(int c);
    int v;
    if ($urandom_range(0, 2) == 0) return rand_conc();
    v = c + $urandom_range(0, 8192) - 4096;
    if (v < 0) v = 0;
    if (v > int'(CONC_MAX)) v = int'(CONC_MAX);
    return v;
  endfunction

  function automatic int rand_vel();
    case ($urandom_range(0, 7))
      0:       return (1 << (VALUE_BITS - 1)) - 1;
      1:       return -(1 << (VALUE_BITS - 1));
      2:       return 0;
      3, 4:    return $urandom_range(0, 1 << 19) - (1 << 18);
      default: return $urandom();
    endcase
  endfunction

  // Offers one point, waits for its transfer and records the prediction.
  // Between bursts the valid is dropped for a random gap.
  task automatic send_point(grid_point_t p);
    in_valid   <= 1'b1;
    in_center  <= p.center;
    in_west    <= p.west;
    in_east    <= p.east;
    in_north   <= p.north;
    in_south   <= p.south;
    in_vel_x   <= p.vel_x;
    in_vel_y   <= p.vel_y;
    in_on_edge <= p.on_edge;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(advance_point(p));
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(9, 24)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Drains the pipeline, then writes all four coefficient registers.
  task automatic set_coefs(int ax, int ay, int dx, int dy);
    logic [CFG_ADDR_W-1:0] regs[4];
    int                    vals[4];
    regs = '{REG_ADV_X, REG_ADV_Y, REG_DIFF_X, REG_DIFF_Y};
    vals = '{ax, ay, dx, dy};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[i];
      cfg_wdata <= vals[i][COEF_W-1:0];
      @(posedge clk);
      case (regs[i])
        REG_ADV_X:  coef_set.adv_x  = vals[i][COEF_W-1:0];
        REG_ADV_Y:  coef_set.adv_y  = vals[i][COEF_W-1:0];
        REG_DIFF_X: coef_set.diff_x = vals[i][COEF_W-1:0];
        REG_DIFF_Y: coef_set.diff_y = vals[i][COEF_W-1:0];
        default:    ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // With the coefficients still at their reset value the advection and
  // diffusion terms are zero, so each result depends on the centre alone.
  task automatic test_after_reset();
    send_point(make_point(int'(CONC_MAX), 0, 0, 0, 0, 32'h7FFFFF, -(1 << 23), 1'b0));
    send_point(make_point(0, int'(CONC_MAX), int'(CONC_MAX), int'(CONC_MAX),
                          int'(CONC_MAX), -(1 << 23), 32'h7FFFFF, 1'b0));
    send_point(make_point(rand_conc(), rand_conc(), rand_conc(), rand_conc(),
                          rand_conc(), rand_vel(), rand_vel(), 1'b0));
  endtask

  // Boundary points keep their centre whatever the coefficients and the
  // other fields hold.
  task automatic test_boundary_points();
    set_coefs(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF);
    send_point(make_point(int'(CONC_MAX), 0, 0, 0, 0, 32'h7FFFFF, 32'h7FFFFF, 1'b1));
    send_point(make_point(0, int'(CONC_MAX), int'(CONC_MAX), int'(CONC_MAX),
                          int'(CONC_MAX), -(1 << 23), -(1 << 23), 1'b1));
    send_point(make_point(rand_conc(), rand_conc(), rand_conc(), rand_conc(),
                          rand_conc(), rand_vel(), rand_vel(), 1'b1));
  endtask

  // Positive velocity looks behind, zero and negative look ahead, on each
  // axis; the last two points land exactly on a rounding half.
  task automatic test_upwind_selection();
    set_coefs(1 << 16, 1 << 15, 6554, 3277);
    send_point(make_point(300000, 100000, 500000, 300000, 300000, 1 << 16, 0, 1'b0));
    send_point(make_point(300000, 100000, 500000, 300000, 300000, 0, 0, 1'b0));
    send_point(make_point(300000, 100000, 500000, 300000, 300000, -(1 << 16), 0, 1'b0));
    send_point(make_point(300000, 300000, 300000, 120000, 450000, 0, 3 << 15, 1'b0));
    send_point(make_point(300000, 300000, 300000, 120000, 450000, 0, 0, 1'b0));
    send_point(make_point(300000, 300000, 300000, 120000, 450000, 0, -(3 << 15), 1'b0));
    send_point(make_point(1 << 16, (1 << 16) - (1 << 15), 1 << 16, 1 << 16, 1 << 16,
                          1, 0, 1'b0));
    send_point(make_point(1 << 16, 1 << 16, (1 << 16) + (1 << 15), 1 << 16, 1 << 16,
                          -1, 0, 1'b0));
  endtask

  // Large coefficients drive the result below zero and past the top.
  task automatic test_clamping();
    set_coefs(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF);
    send_point(make_point(int'(CONC_MAX), int'(CONC_MAX), int'(CONC_MAX), int'(CONC_MAX),
                          int'(CONC_MAX), 0, 0, 1'b0));
    send_point(make_point(1 << 20, int'(CONC_MAX), int'(CONC_MAX), int'(CONC_MAX),
                          int'(CONC_MAX), 0, 0, 1'b0));
    send_point(make_point(int'(CONC_MAX), 0, 0, 0, 0, 0, 0, 1'b0));
    send_point(make_point(int'(CONC_MAX), 0, int'(CONC_MAX), int'(CONC_MAX),
                          int'(CONC_MAX), 32'h7FFFFF, 0, 1'b0));
    send_point(make_point(int'(CONC_MAX), int'(CONC_MAX), 0, int'(CONC_MAX),
                          0, -(1 << 23), -(1 << 23), 1'b0));
  endtask

  // Random points over several coefficient sets: half of them physically sensible
  // coefficients, plus zero, full-scale and fully random sets.
  task automatic test_random_stream();
    grid_point_t p;
    int          c;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        2:       set_coefs(0, 0, 0, 0);
        3:       set_coefs(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF);
        1, 5:    set_coefs($urandom_range(0, 32'hFFFFFF), $urandom_range(0, 32'hFFFFFF),
                           $urandom_range(0, 32'hFFFFFF), $urandom_range(0, 32'hFFFFFF));
        default: set_coefs($urandom_range(0, 1 << 16), $urandom_range(0, 1 << 16),
                           $urandom_range(0, 1 << 14), $urandom_range(0, 1 << 14));
      endcase
      // The first phase streams back to back with no sender gaps.
      gaps_on = (ph != 0);
      for (int i = 0; i < PHASE_LEN; i++) begin
        c         = rand_conc();
        p.center  = c[VAL_W-1:0];
        p.west    = VAL_W'(rand_neighbour(c));
        p.east    = VAL_W'(rand_neighbour(c));
        p.north   = VAL_W'(rand_neighbour(c));
        p.south   = VAL_W'(rand_neighbour(c));
        p.vel_x   = VALUE_BITS'(rand_vel());
        p.vel_y   = VALUE_BITS'(rand_vel());
        p.on_edge = ($urandom_range(0, 9) == 0);
        send_point(p);
      end
    end
    gaps_on = 1'b1;
  endtask

  // Receiver stall pattern: free-running, light, heavy or periodic stretches.
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_hold <= $urandom_range(32, 200);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_hold[3];
    endcase
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin : check_results
    point_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: updated=%h saturated=%b",
               out_updated, out_saturated);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_updated !== want.updated) begin
          $error("updated: expected %h, got %h", want.updated, out_updated);
          fail_count++;
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, out_saturated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= REG_ADV_X;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_center  <= '0;
    in_west    <= '0;
    in_east    <= '0;
    in_north   <= '0;
    in_south   <= '0;
    in_vel_x   <= '0;
    in_vel_y   <= '0;
    in_on_edge <= 1'b0;
    coef_set   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_boundary_points();
    test_upwind_selection();
    test_clamping();
    test_random_stream();

    // Wait for the last results, then watch for stray transfers.
    drain();
    repeat (4 * NSTAGE) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
